### rtl/pixel_brightness_via_hsv_top_assert.svh
// assertion macros for the pixel brightness block
`ifndef PIXEL_BRIGHTNESS_VIA_HSV_TOP_ASSERT_SVH
`define PIXEL_BRIGHTNESS_VIA_HSV_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PBH_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PBH_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/pbh_pkg.sv
// ----------------------------------------------------------------------------
// pbh_pkg
// shared constants and types for the pixel brightness block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pbh_pkg;
  localparam int unsigned PixW   = 32;
  localparam int unsigned LevelW = 9;
  localparam logic [7:0] HueSext = 8'd43;
  localparam logic [7:0] HueGrn  = 8'd85;
  localparam logic [7:0] HueBlu  = 8'd171;

  typedef enum logic [1:0] {MaxRed, MaxGrn, MaxBlu} max_sel_e;
endpackage

### rtl/pixel_brightness_via_hsv_top.sv
// ----------------------------------------------------------------------------
// pixel_brightness_via_hsv_top
// sets (func_i low) or offsets (func_i high) the hsv brightness of an argb pixel, alpha passes through
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// One item (func, pixel, level) is taken at every clock where start_i is high;
// busy_o is tied low since the pipeline never backs up. The adjusted pixel
// appears on pixel_out_o with done_o high after the pipeline of 1 front
// stage, 8 stages of the saturation divider, 8 of the hue divider, 4 to
// rebuild rgb. Sustained rate is one pixel per clock. The receiver cannot stall.
module pixel_brightness_via_hsv_top
  import pbh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              func_i,
  input  logic [PixW-1:0]   pixel_in_i,
  input  logic signed [LevelW-1:0] level_i,
  output logic              done_o,
  output logic [PixW-1:0]   pixel_out_o
);
`include "pixel_brightness_via_hsv_top_assert.svh"

  assign busy_o = 1'b0;

  // ---- stage 0: max, min, target brightness
  logic [7:0] r, g, b, mx, mn;
  logic signed [9:0] br;
  logic [7:0] v_d;
  max_sel_e   sel_d;
  assign r = pixel_in_i[23:16];
  assign g = pixel_in_i[15:8];
  assign b = pixel_in_i[7:0];
  always_comb begin
    mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
    mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
    br = func_i ? ($signed({2'b00, mx}) + 10'(level_i)) : 10'(level_i);
    if (br < 0)            v_d = 8'd0;
    else if (br > 10'sd255) v_d = 8'd255;
    else                   v_d = br[7:0];
    if (mx == r)      sel_d = MaxRed;
    else if (mx == g) sel_d = MaxGrn;
    else              sel_d = MaxBlu;
  end

  // numerator of hue difference, sign kept apart
  logic [7:0] dif_a, dif_b;
  always_comb begin
    unique case (sel_d)
      MaxRed:  begin dif_a = g; dif_b = b; end
      MaxGrn:  begin dif_a = b; dif_b = r; end
      default: begin dif_a = r; dif_b = g; end
    endcase
  end

  // tag layout: alpha, v, sel, sign, |diff|*43, d
  localparam int unsigned TagW = 8 + 8 + 2 + 1 + 14 + 8;
  logic            s0_vld_q;
  logic [TagW-1:0] s0_tag_q;
  logic [15:0]     s0_num_q;
  logic [7:0]      s0_mx_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i;
    end
  end
  logic [7:0]  adif;
  logic        neg;
  assign neg  = dif_a < dif_b;
  assign adif = neg ? (dif_b - dif_a) : (dif_a - dif_b);
  always_ff @(posedge clk_i) begin
    s0_num_q <= 16'(mx - mn) * 16'd255;
    s0_mx_q  <= mx;
    s0_tag_q <= {pixel_in_i[31:24], v_d, sel_d, neg, 14'(adif) * 14'd43, 8'(mx - mn)};
  end

  // ---- saturation divider, max 0 gives s 0 since numerator is 0
  logic            sd_vld;
  logic [7:0]      s_quo;
  logic [TagW-1:0] sd_tag;
  pbh_div #(.NumW(16), .DenW(8), .QW(8), .TagW(TagW)) u_sdiv (
    .clk_i, .rst_ni, .vld_i(s0_vld_q), .num_i(s0_num_q),
    .den_i(s0_mx_q | {7'd0, s0_mx_q == 8'd0}), .tag_i(s0_tag_q),
    .vld_o(sd_vld), .quo_o(s_quo), .tag_o(sd_tag)
  );

  // ---- hue divider, quotient of |diff|*43/d is at most 43
  localparam int unsigned HTagW = TagW + 8;
  logic             hd_vld;
  logic [7:0]       h_quo;
  logic [HTagW-1:0] hd_tag;
  pbh_div #(.NumW(14), .DenW(8), .QW(8), .TagW(HTagW)) u_hdiv (
    .clk_i, .rst_ni, .vld_i(sd_vld), .num_i(sd_tag[21:8]),
    .den_i(sd_tag[7:0] | {7'd0, sd_tag[7:0] == 8'd0}), .tag_i({s_quo, sd_tag}),
    .vld_o(hd_vld), .quo_o(h_quo), .tag_o(hd_tag)
  );

  // ---- rebuild stage a: hue, region, remainder
  logic [7:0] ra_a, ra_v, ra_s, ra_h;
  max_sel_e   ra_sel;
  logic       ra_neg;
  logic [7:0] hq;
  assign ra_s   = hd_tag[HTagW-1 -: 8];
  assign ra_a   = hd_tag[TagW-1 -: 8];
  assign ra_v   = hd_tag[TagW-9 -: 8];
  assign ra_sel = max_sel_e'(hd_tag[TagW-17 -: 2]);
  assign ra_neg = hd_tag[22];
  assign hq     = ra_neg ? (8'd0 - h_quo) : h_quo;
  always_comb begin
    unique case (ra_sel)
      MaxRed:  ra_h = hq;
      MaxGrn:  ra_h = HueGrn + hq;
      default: ra_h = HueBlu + hq;
    endcase
  end

  logic       a_vld_q;
  logic [7:0] a_a_q, a_v_q, a_s_q, a_rem_q;
  logic [2:0] a_reg_q;
  logic [2:0] reg_d;
  logic [7:0] rb;
  always_comb begin
    if      (ra_h >= 8'd215) reg_d = 3'd5;
    else if (ra_h >= 8'd172) reg_d = 3'd4;
    else if (ra_h >= 8'd129) reg_d = 3'd3;
    else if (ra_h >= 8'd86)  reg_d = 3'd2;
    else if (ra_h >= HueSext) reg_d = 3'd1;
    else                     reg_d = 3'd0;
    rb = 8'(reg_d) * HueSext;
  end
  // region 5 of h up to 255 gives rem 40 max, times 6 fits 8 bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else         a_vld_q <= hd_vld;
  end
  always_ff @(posedge clk_i) begin
    a_a_q   <= ra_a;
    a_v_q   <= ra_v;
    a_s_q   <= ra_s;
    a_reg_q <= reg_d;
    a_rem_q <= 8'((ra_h - rb) * 8'd6);
  end

  // ---- stage b: s*rem products
  logic        b_vld_q;
  logic [7:0]  b_a_q, b_v_q, b_s_q, b_sq_q, b_st_q;
  logic [2:0]  b_reg_q;
  logic [15:0] sq_p, st_p;
  assign sq_p = 16'(a_s_q) * 16'(a_rem_q);
  assign st_p = 16'(a_s_q) * 16'(8'd255 - a_rem_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else         b_vld_q <= a_vld_q;
  end
  always_ff @(posedge clk_i) begin
    b_a_q <= a_a_q; b_v_q <= a_v_q; b_s_q <= a_s_q; b_reg_q <= a_reg_q;
    b_sq_q <= sq_p[15:8];
    b_st_q <= st_p[15:8];
  end

  // ---- stage c: v products give p, q, t
  logic        c_vld_q;
  logic [7:0]  c_a_q, c_v_q, c_p_q, c_qq_q, c_t_q, c_s_q;
  logic [2:0]  c_reg_q;
  logic [15:0] pp, qp, tp;
  assign pp = 16'(b_v_q) * 16'(8'd255 - b_s_q);
  assign qp = 16'(b_v_q) * 16'(8'd255 - b_sq_q);
  assign tp = 16'(b_v_q) * 16'(8'd255 - b_st_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else         c_vld_q <= b_vld_q;
  end
  always_ff @(posedge clk_i) begin
    c_a_q <= b_a_q; c_v_q <= b_v_q; c_reg_q <= b_reg_q; c_s_q <= b_s_q;
    c_p_q <= pp[15:8]; c_qq_q <= qp[15:8]; c_t_q <= tp[15:8];
  end

  // ---- stage d: region select, grey pixel override
  logic       d_vld_q;
  logic [PixW-1:0] d_pix_q;
  logic [7:0] ro, go, bo;
  always_comb begin
    unique case (c_reg_q)
      3'd0:    begin ro = c_v_q;  go = c_t_q;  bo = c_p_q;  end
      3'd1:    begin ro = c_qq_q; go = c_v_q;  bo = c_p_q;  end
      3'd2:    begin ro = c_p_q;  go = c_v_q;  bo = c_t_q;  end
      3'd3:    begin ro = c_p_q;  go = c_qq_q; bo = c_v_q;  end
      3'd4:    begin ro = c_t_q;  go = c_p_q;  bo = c_v_q;  end
      default: begin ro = c_v_q;  go = c_p_q;  bo = c_qq_q; end
    endcase
    if (c_s_q == 8'd0) begin
      ro = c_v_q; go = c_v_q; bo = c_v_q;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else         d_vld_q <= c_vld_q;
  end
  always_ff @(posedge clk_i) begin
    d_pix_q <= {c_a_q, ro, go, bo};
  end

  assign done_o      = d_vld_q;
  assign pixel_out_o = d_pix_q;

  `PBH_ASSERT_IMP(a_busy_low, clk_i, rst_ni, 1'b1, !busy_o)
  `PBH_ASSERT_NXT(a_front_vld, clk_i, rst_ni, start_i, s0_vld_q)
  `PBH_ASSERT_NXT(a_tail_vld, clk_i, rst_ni, c_vld_q, done_o)
  `PBH_ASSERT_IMP(a_region_rng, clk_i, rst_ni, a_vld_q, a_reg_q <= 3'd5)
endmodule

### rtl/pbh_div.sv
// ----------------------------------------------------------------------------
// pbh_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pbh_div
  import pbh_pkg::*;
#(
  parameter int unsigned NumW = 16,
  parameter int unsigned DenW = 8,
  parameter int unsigned QW   = 8,
  parameter int unsigned TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            vld_o,
  output logic [QW-1:0]   quo_o,
  output logic [TagW-1:0] tag_o
);
  // element k feeds stage k, element QW is the last stage output
  logic                  vld_s [QW+1];
  logic [NumW-1:0]       rem_s [QW+1];
  logic [DenW-1:0]       den_s [QW+1];
  logic [QW-1:0]         quo_s [QW+1];
  logic [TagW-1:0]       tag_s [QW+1];

  assign vld_s[0] = vld_i;
  assign rem_s[0] = num_i;
  assign den_s[0] = den_i;
  assign quo_s[0] = '0;
  assign tag_s[0] = tag_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned Sh = QW - 1 - k;
    logic [NumW+QW-1:0] dsh;
    logic               ge;
    logic               vld_q;
    logic [NumW-1:0]    rem_q;
    logic [DenW-1:0]    den_q;
    logic [QW-1:0]      quo_q;
    logic [TagW-1:0]    tag_q;
    assign dsh = {{QW{1'b0}}, {(NumW-DenW){1'b0}}, den_s[k]} << Sh;
    assign ge  = {{QW{1'b0}}, rem_s[k]} >= dsh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_s[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q <= ge ? NumW'({{QW{1'b0}}, rem_s[k]} - dsh) : rem_s[k];
      den_q <= den_s[k];
      quo_q <= quo_s[k] | (QW'(ge) << Sh);
      tag_q <= tag_s[k];
    end
    assign vld_s[k+1] = vld_q;
    assign rem_s[k+1] = rem_q;
    assign den_s[k+1] = den_q;
    assign quo_s[k+1] = quo_q;
    assign tag_s[k+1] = tag_q;
  end

  assign vld_o = vld_s[QW];
  assign quo_o = quo_s[QW];
  assign tag_o = tag_s[QW];
endmodule
